[rtl/djb2ht_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// Shared constants and state type for the djb2 counting hash table.
// No dependencies; imported by djb2_counting_hash_table_core.

package djb2ht_pkg;

    localparam int HASH_W             = 64;
    localparam int COUNT_W            = 32;
    localparam int BYTE_W             = 8;
    localparam int SLOT_OUT_W         = 4;
    localparam int HASH_SHIFT         = 5;
    localparam int TABLE_SIZE_DEFAULT = 16;

    localparam logic [HASH_W-1:0] HASH_START = HASH_W'(5381);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MOD,
        S_READ,
        S_CHECK
    } t_state;

endpackage

`default_nettype wire

[rtl/djb2_counting_hash_table_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// djb2 counting hash table: byte-serial hashing and a linear-probing count table.
// Depends on djb2ht_pkg for constants and the state type.

// Key bytes are taken one per cycle while busy is low; a byte without the last
// mark leaves busy low. On the last byte the 64-bit hash is reduced modulo
// TABLE_SIZE by a shift-subtract unit that folds one hash byte per cycle,
// then the table memory is probed slot by slot (read, then compare), so a key
// holds busy through the reduction and all its probes, with probes from 1 to
// TABLE_SIZE. Each key yields one word on the result ports, marked by o_valid for
// exactly one cycle; the receiver cannot stall it, and the next key may start
// in that same cycle. After reset the block sweeps the table memory clear, one
// slot per cycle, holding busy high until every slot is cleared.

module djb2_counting_hash_table_core
    import djb2ht_pkg::*;
#(
    parameter int TABLE_SIZE = TABLE_SIZE_DEFAULT
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic [BYTE_W-1:0]     i_key_byte,
    input  wire logic                  i_last_byte,
    output logic                       o_valid,
    output logic [SLOT_OUT_W-1:0]      o_slot_index,
    output logic [COUNT_W-1:0]         o_slot_count,
    output logic [HASH_W-1:0]          o_stored_hash,
    output logic                       o_table_full
);

    localparam int IDX_W   = $clog2(TABLE_SIZE);
    localparam int MOD_W   = IDX_W + BYTE_W;
    localparam int ENTRY_W = COUNT_W + HASH_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SIZE - 1);

    t_state                r_state, n_state;
    logic [HASH_W-1:0]     r_hash, n_hash;
    logic [HASH_W-1:0]     r_probe, n_probe;
    logic [IDX_W-1:0]      r_idx, n_idx;
    logic [IDX_W-1:0]      r_tries, n_tries;
    logic [2:0]            r_mod_cnt, n_mod_cnt;
    logic                  r_valid, n_valid;
    logic [IDX_W-1:0]      r_out_idx, n_out_idx;
    logic [COUNT_W-1:0]    r_out_count, n_out_count;
    logic [HASH_W-1:0]     r_out_hash, n_out_hash;
    logic                  r_out_full, n_out_full;

    logic [ENTRY_W-1:0]    r_table [TABLE_SIZE];
    logic [ENTRY_W-1:0]    r_rd_data;

    logic                  accept;
    logic [HASH_W-1:0]     hash_upd;
    logic [BYTE_W-1:0]     mod_byte;
    logic [MOD_W-1:0]      mod_x;
    logic [IDX_W-1:0]      mod_rem;
    logic [COUNT_W-1:0]    rd_count;
    logic [HASH_W-1:0]     rd_key;
    logic [COUNT_W-1:0]    count_inc;
    logic                  hit;
    logic                  probes_done;
    logic [IDX_W-1:0]      idx_inc;
    logic                  mem_we;
    logic [ENTRY_W-1:0]    mem_wdata;

    assign busy    = (r_state != S_IDLE);
    assign accept  = start && !busy;
    assign hash_upd = (r_hash << HASH_SHIFT) + r_hash + HASH_W'(i_key_byte);

    assign mod_byte = r_probe[{r_mod_cnt, 3'b000} +: BYTE_W];

    always_comb begin
        mod_x = {r_idx, mod_byte};
        for (int k = 7; k >= 0; k--) begin
            if (mod_x >= (MOD_W'(TABLE_SIZE) << k)) begin
                mod_x = mod_x - (MOD_W'(TABLE_SIZE) << k);
            end
        end
    end
    assign mod_rem = mod_x[IDX_W-1:0];

    assign rd_count    = r_rd_data[ENTRY_W-1:HASH_W];
    assign rd_key      = r_rd_data[HASH_W-1:0];
    assign hit         = (rd_count == '0) || (rd_key == r_probe);
    assign count_inc   = (rd_count == '1) ? rd_count : rd_count + 1'b1;
    assign probes_done = (r_tries == LAST_IDX);
    assign idx_inc     = ((r_probe == '1) || (r_idx == LAST_IDX)) ? '0 : r_idx + 1'b1;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_idx == LAST_IDX) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (accept && i_last_byte) n_state = S_MOD;
            end
            S_MOD: begin
                if (r_mod_cnt == '0) n_state = S_READ;
            end
            S_READ: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (hit || probes_done) n_state = S_IDLE;
                else n_state = S_READ;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_hash      = r_hash;
        n_probe     = r_probe;
        n_idx       = r_idx;
        n_tries     = r_tries;
        n_mod_cnt   = r_mod_cnt;
        n_valid     = 1'b0;
        n_out_idx   = r_out_idx;
        n_out_count = r_out_count;
        n_out_hash  = r_out_hash;
        n_out_full  = r_out_full;
        mem_we      = 1'b0;
        mem_wdata   = {count_inc, r_probe};
        unique case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_wdata = '0;
                n_idx     = (r_idx == LAST_IDX) ? '0 : r_idx + 1'b1;
            end
            S_IDLE: begin
                if (accept) begin
                    if (i_last_byte) begin
                        n_hash    = HASH_START;
                        n_probe   = hash_upd;
                        n_idx     = '0;
                        n_tries   = '0;
                        n_mod_cnt = 3'd7;
                    end else begin
                        n_hash = hash_upd;
                    end
                end
            end
            S_MOD: begin
                n_idx     = mod_rem;
                n_mod_cnt = r_mod_cnt - 1'b1;
            end
            S_READ: begin
            end
            S_CHECK: begin
                if (hit) begin
                    mem_we      = 1'b1;
                    n_valid     = 1'b1;
                    n_out_idx   = r_idx;
                    n_out_count = count_inc;
                    n_out_hash  = r_probe;
                    n_out_full  = 1'b0;
                end else if (probes_done) begin
                    n_valid     = 1'b1;
                    n_out_idx   = '0;
                    n_out_count = '0;
                    n_out_hash  = '0;
                    n_out_full  = 1'b1;
                end else begin
                    n_probe = r_probe + 1'b1;
                    n_idx   = idx_inc;
                    n_tries = r_tries + 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_hash    <= HASH_START;
            r_idx     <= '0;
            r_tries   <= '0;
            r_mod_cnt <= '0;
            r_valid   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_hash    <= n_hash;
            r_idx     <= n_idx;
            r_tries   <= n_tries;
            r_mod_cnt <= n_mod_cnt;
            r_valid   <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_probe     <= n_probe;
        r_out_idx   <= n_out_idx;
        r_out_count <= n_out_count;
        r_out_hash  <= n_out_hash;
        r_out_full  <= n_out_full;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_table[r_idx] <= mem_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_table[r_idx];
    end

    assign o_valid       = r_valid;
    assign o_slot_index  = SLOT_OUT_W'(r_out_idx);
    assign o_slot_count  = r_out_count;
    assign o_stored_hash = r_out_hash;
    assign o_table_full  = r_out_full;

    a_valid_after_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_state) == S_CHECK)
        else $error("result word without a preceding table check");

    a_hit_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_table_full) |-> (o_slot_count != '0))
        else $error("counted slot reports a zero count");

    a_full_word_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_table_full) |-> (o_slot_count == '0 && o_stored_hash == '0))
        else $error("full-table word carries nonzero payload");

    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= LAST_IDX)
        else $error("slot index beyond table");

    a_last_sets_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_last_byte) |=> busy)
        else $error("last key byte did not start a lookup");

endmodule

`default_nettype wire
